// ----- src/mbrm_pkg.sv -----
`default_nettype none

package mbrm_pkg;

  localparam int NUM_REGS     = 64;
  localparam int MAX_IO_WORDS = 32;
  localparam int ADDR_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W        = $clog2(MAX_IO_WORDS + 1);
  localparam int WORD_W       = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_DIAGNOSTICS  = 8'd8;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;
  localparam logic [7:0] FC_REPORT_ID    = 8'd17;
  localparam logic [7:0] FC_ENCAP        = 8'd43;
  localparam logic [7:0] FC_EXC_FLAG     = 8'h80;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_DATA   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BASE   = 1'd1;

  typedef enum logic [1:0] {
    EXC_NONE     = 2'd0,
    EXC_ADDRESS  = 2'd1,
    EXC_DEVICE   = 2'd2,
    EXC_FUNCTION = 2'd3
  } exc_t;

  typedef struct packed {
    logic              action;
    logic [7:0]        fn_code;
    logic [WORD_W-1:0] start_address;
    logic [WORD_W-1:0] word_count;
    logic [WORD_W-1:0] value;
  } mbrm_req_t;

  typedef struct packed {
    logic [7:0]        resp_function;
    exc_t              exception;
    logic [7:0]        byte_count;
    logic [WORD_W-1:0] echo_address;
    logic [WORD_W-1:0] word;
    logic              last;
  } mbrm_resp_t;

  function automatic mbrm_resp_t exc_resp(input logic [7:0] fn, input exc_t exc);
    mbrm_resp_t r;
    r.resp_function = fn + FC_EXC_FLAG;
    r.exception     = exc;
    r.byte_count    = 8'd0;
    r.echo_address  = '0;
    r.word          = '0;
    r.last          = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/mbrm_ram.sv -----
`default_nettype none

module mbrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/modbus_register_map_server.sv -----
// A response that needs no store read is registered into the output pair in the cycle
// after its word is accepted. A read of N registers streams N words, one per cycle while
// out_ready holds; the next word is taken once the last read has landed and the skid is empty.
// The single store read port sets throughput: one register per cycle while out_ready holds.
// Synchronous active-low reset clears the bases, write state and the per-entry valid bits,
// so every register reads as zero until written; no clearing pass is needed.
`default_nettype none

module modbus_register_map_server
  import mbrm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mbrm_req_t            in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mbrm_resp_t                out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [WORD_W-1:0]  holding_base_r, input_base_r;
  logic [NUM_REGS-1:0] valid_r;

  logic [WORD_W-1:0]  pending_r, pending_nxt;
  logic [ADDR_W-1:0]  wp_r, wp_nxt;
  logic               discard_r, discard_nxt;
  logic [WORD_W-1:0]  saved_start_r, saved_start_nxt;
  logic [WORD_W-1:0]  saved_count_r, saved_count_nxt;

  logic [7:0]         rd_fn_r, rd_fn_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               rd_vbit_r, rd_vbit_nxt;

  logic               out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  mbrm_resp_t         out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  logic               accept, pop, push, rd_issue;
  mbrm_resp_t         push_data;
  logic [1:0]         occ;
  logic [CNT_W-1:0]   idx_inc;

  logic [WORD_W-1:0]  base;
  logic [WORD_W:0]    off_ext, span;
  logic               below, range_ok, single_ok;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata, ram_q;

  mbrm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_REGS),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  assign in_ready  = (state_r == ST_IDLE) && !rd_pend_r && !skid_v_r;
  assign accept    = in_valid && in_ready;
  assign pop       = out_v_r && out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // words held or in flight towards the output pair
  assign occ      = {1'b0, out_v_r} + {1'b0, skid_v_r} + {1'b0, rd_pend_r};
  assign rd_issue = (state_r == ST_READ) && ((occ < 2'd2) || (occ == 2'd2 && pop));
  assign idx_inc  = rd_idx_r + CNT_W'(1);

  // address checks
  always_comb begin
    base      = (in_data.fn_code == FC_READ_INPUT) ? input_base_r : holding_base_r;
    off_ext   = {1'b0, in_data.start_address} - {1'b0, base};
    below     = off_ext[WORD_W];
    span      = {1'b0, off_ext[WORD_W-1:0]} + {1'b0, in_data.word_count};
    range_ok  = !below && (span <= (WORD_W+1)'(NUM_REGS))
                && (in_data.word_count <= WORD_W'(MAX_IO_WORDS))
                && (in_data.word_count != '0);
    single_ok = !below && (off_ext[WORD_W-1:0] < WORD_W'(NUM_REGS));
  end

  always_comb begin
    state_nxt       = state_r;
    pending_nxt     = pending_r;
    wp_nxt          = wp_r;
    discard_nxt     = discard_r;
    saved_start_nxt = saved_start_r;
    saved_count_nxt = saved_count_r;
    rd_fn_nxt       = rd_fn_r;
    rd_cnt_nxt      = rd_cnt_r;
    rd_idx_nxt      = rd_idx_r;
    rd_addr_nxt     = rd_addr_r;
    rd_pend_nxt     = rd_issue;
    rd_last_nxt     = rd_last_r;
    rd_vbit_nxt     = rd_vbit_r;
    push            = 1'b0;
    push_data       = exc_resp(in_data.fn_code, EXC_FUNCTION);
    ram_we          = 1'b0;
    ram_waddr       = wp_r;
    ram_wdata       = in_data.value;

    if (rd_pend_r) begin
      push                   = 1'b1;
      push_data.resp_function = rd_fn_r;
      push_data.exception    = EXC_NONE;
      push_data.byte_count   = 8'({rd_cnt_r, 1'b0});
      push_data.echo_address = '0;
      push_data.word         = rd_vbit_r ? ram_q : '0;
      push_data.last         = rd_last_r;
    end

    if (rd_issue) begin
      rd_addr_nxt = rd_addr_r + ADDR_W'(1);
      rd_idx_nxt  = idx_inc;
      rd_last_nxt = (idx_inc == rd_cnt_r);
      rd_vbit_nxt = valid_r[rd_addr_r];
      if (idx_inc == rd_cnt_r) begin
        state_nxt = ST_IDLE;
      end
    end

    if (accept) begin
      if (in_data.action == ACT_DATA) begin
        if (pending_r != '0) begin
          ram_we      = !discard_r;
          wp_nxt      = wp_r + ADDR_W'(1);
          pending_nxt = pending_r - WORD_W'(1);
          if (pending_r == WORD_W'(1)) begin
            push = 1'b1;
            if (discard_r) begin
              discard_nxt = 1'b0;
              push_data   = exc_resp(FC_WRITE_MULTI, EXC_ADDRESS);
            end else begin
              push_data.resp_function = FC_WRITE_MULTI;
              push_data.exception    = EXC_NONE;
              push_data.byte_count   = 8'd0;
              push_data.echo_address = saved_start_r;
              push_data.word         = saved_count_r;
              push_data.last         = 1'b1;
            end
          end
        end
      end else begin
        // a new header drops any pending write
        pending_nxt = '0;
        discard_nxt = 1'b0;
        case (in_data.fn_code) inside
          FC_READ_HOLDING, FC_READ_INPUT: begin
            if (range_ok) begin
              state_nxt   = ST_READ;
              rd_fn_nxt   = in_data.fn_code;
              rd_cnt_nxt  = in_data.word_count[CNT_W-1:0];
              rd_idx_nxt  = '0;
              rd_addr_nxt = off_ext[ADDR_W-1:0];
            end else begin
              push      = 1'b1;
              push_data = exc_resp(in_data.fn_code, EXC_ADDRESS);
            end
          end
          FC_WRITE_SINGLE: begin
            push = 1'b1;
            if (single_ok) begin
              ram_we                 = 1'b1;
              ram_waddr              = off_ext[ADDR_W-1:0];
              push_data.resp_function = FC_WRITE_SINGLE;
              push_data.exception    = EXC_NONE;
              push_data.byte_count   = 8'd0;
              push_data.echo_address = in_data.start_address;
              push_data.word         = in_data.value;
              push_data.last         = 1'b1;
            end else begin
              push_data = exc_resp(in_data.fn_code, EXC_ADDRESS);
            end
          end
          FC_WRITE_MULTI: begin
            if (range_ok) begin
              pending_nxt     = in_data.word_count;
              wp_nxt          = off_ext[ADDR_W-1:0];
              saved_start_nxt = in_data.start_address;
              saved_count_nxt = in_data.word_count;
            end else if (in_data.word_count == '0) begin
              push      = 1'b1;
              push_data = exc_resp(in_data.fn_code, EXC_ADDRESS);
            end else begin
              discard_nxt = 1'b1;
              pending_nxt = in_data.word_count;
              wp_nxt      = '0;
            end
          end
          FC_DIAGNOSTICS, FC_REPORT_ID, FC_ENCAP: begin
            push      = 1'b1;
            push_data = exc_resp(in_data.fn_code, EXC_DEVICE);
          end
          default: begin
            push      = 1'b1;
            push_data = exc_resp(in_data.fn_code, EXC_FUNCTION);
          end
        endcase
      end
    end
  end

  // two-deep output: out register plus skid
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      if (skid_v_r) begin
        out_d_nxt = skid_d_r;
        if (push) begin
          skid_d_nxt = push_data;
        end else begin
          skid_v_nxt = 1'b0;
        end
      end else if (push) begin
        out_d_nxt = push_data;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      holding_base_r <= '0;
      input_base_r   <= '0;
      valid_r        <= '0;
      pending_r      <= '0;
      wp_r           <= '0;
      discard_r      <= 1'b0;
      saved_start_r  <= '0;
      saved_count_r  <= '0;
      rd_pend_r      <= 1'b0;
      out_v_r        <= 1'b0;
      skid_v_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pending_r     <= pending_nxt;
      wp_r          <= wp_nxt;
      discard_r     <= discard_nxt;
      saved_start_r <= saved_start_nxt;
      saved_count_r <= saved_count_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_v_r       <= out_v_nxt;
      skid_v_r      <= skid_v_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOLDING_BASE: holding_base_r <= cfg_data;
          CFG_INPUT_BASE:   input_base_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_fn_r   <= rd_fn_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_addr_r <= rd_addr_nxt;
    rd_last_r <= rd_last_nxt;
    rd_vbit_r <= rd_vbit_nxt;
    out_d_r   <= out_d_nxt;
    skid_d_r  <= skid_d_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && out_v_r && skid_v_r && !pop))
    else $error("output pair overflow");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while out register is empty");

  a_landing_vs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !accept)
    else $error("store read lands while an item is accepted");

  a_discard_pending: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (pending_r != '0))
    else $error("discard set with no words pending");

  a_read_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (rd_idx_r < rd_cnt_r))
    else $error("read index beyond request count");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import mbrm_pkg::*;

  localparam int GAP_PCT = 26;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] FC_SPARE_LOW  = 8'h00;
  localparam logic [7:0] FC_SPARE_HIGH = 8'hFF;
  localparam logic [7:0] FC_SPARE_WRAP = 8'h85;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mbrm_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mbrm_resp_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  bit send_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int fail_count = 0;
  int items_done = 0;

  // register map image and write-multiple tracking
  logic [WORD_W-1:0] reg_image [NUM_REGS] = '{default: '0};
  logic [WORD_W-1:0] hold_base = '0;
  logic [WORD_W-1:0] in_base = '0;
  logic [WORD_W-1:0] words_left = '0;
  int unsigned fill_ptr = 0;
  bit drop_data = 1'b0;
  logic [WORD_W-1:0] burst_start = '0;
  logic [WORD_W-1:0] burst_count = '0;
  mbrm_resp_t reply_q [$];

  modbus_register_map_server u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    out_ready = !sink_gaps || ($urandom_range(0, 99) >= GAP_PCT);
  end

  function automatic void push_reply(input logic [7:0] fn, input exc_t exc,
                                     input logic [7:0] bytes, input logic [15:0] addr,
                                     input logic [15:0] w, input logic fin);
    mbrm_resp_t r;
    r.resp_function = fn;
    r.exception     = exc;
    r.byte_count    = bytes;
    r.echo_address  = addr;
    r.word          = w;
    r.last          = fin;
    reply_q.push_back(r);
  endfunction

  function automatic void push_fault(input logic [7:0] fn, input exc_t exc);
    push_reply(fn + FC_EXC_FLAG, exc, 8'd0, 16'd0, 16'd0, 1'b1);
  endfunction

  // no wrap: sums are taken at 32 bits
  function automatic bit span_ok(input int unsigned s, input int unsigned c,
                                 input int unsigned b);
    return (s >= b) && (s + c <= b + NUM_REGS) && (c <= MAX_IO_WORDS) && (c != 0);
  endfunction

  // Returns 0 when the word is ignored by the block.
  function automatic bit serve_request(input mbrm_req_t r);
    int unsigned s, c, b, i;
    s = r.start_address;
    c = r.word_count;
    if (r.action == ACT_DATA) begin
      if (words_left == 0) return 1'b0;
      if (!drop_data && fill_ptr < NUM_REGS) reg_image[fill_ptr] = r.value;
      fill_ptr++;
      words_left--;
      if (words_left != 0) return 1'b1;
      if (drop_data) begin
        drop_data = 1'b0;
        push_fault(FC_WRITE_MULTI, EXC_ADDRESS);
      end else begin
        push_reply(FC_WRITE_MULTI, EXC_NONE, 8'd0, burst_start, burst_count, 1'b1);
      end
      return 1'b1;
    end
    // a header abandons any write still pending
    words_left = '0;
    drop_data = 1'b0;
    case (r.fn_code)
      FC_READ_HOLDING, FC_READ_INPUT: begin
        b = (r.fn_code == FC_READ_HOLDING) ? hold_base : in_base;
        if (!span_ok(s, c, b)) begin
          push_fault(r.fn_code, EXC_ADDRESS);
        end else begin
          for (i = 0; i < c; i++)
            push_reply(r.fn_code, EXC_NONE, 8'(c * 2), 16'd0, reg_image[s - b + i],
                       (i + 1 == c));
        end
      end
      FC_WRITE_SINGLE: begin
        if (s < hold_base || s - hold_base >= NUM_REGS) begin
          push_fault(r.fn_code, EXC_ADDRESS);
        end else begin
          reg_image[s - hold_base] = r.value;
          push_reply(FC_WRITE_SINGLE, EXC_NONE, 8'd0, r.start_address, r.value, 1'b1);
        end
      end
      FC_WRITE_MULTI: begin
        if (!span_ok(s, c, hold_base)) begin
          if (c == 0) begin
            push_fault(r.fn_code, EXC_ADDRESS);
          end else begin
            drop_data = 1'b1;
            words_left = r.word_count;
            fill_ptr = 0;
          end
        end else begin
          words_left = r.word_count;
          fill_ptr = s - hold_base;
          burst_start = r.start_address;
          burst_count = r.word_count;
        end
      end
      FC_DIAGNOSTICS, FC_REPORT_ID, FC_ENCAP: push_fault(r.fn_code, EXC_DEVICE);
      default: push_fault(r.fn_code, EXC_FUNCTION);
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    if (fail_count <= 40) $display("tb: %s mismatch, got %0h want %0h", what, got, want);
  endtask

  task automatic check_reply(input mbrm_resp_t got);
    mbrm_resp_t want;
    if (reply_q.size() == 0) begin
      report_mismatch("unexpected word", got.word, 0);
      return;
    end
    want = reply_q.pop_front();
    if (got.resp_function !== want.resp_function)
      report_mismatch("resp_function", got.resp_function, want.resp_function);
    if (got.exception !== want.exception)
      report_mismatch("exception", got.exception, want.exception);
    if (got.byte_count !== want.byte_count)
      report_mismatch("byte_count", got.byte_count, want.byte_count);
    if (got.echo_address !== want.echo_address)
      report_mismatch("echo_address", got.echo_address, want.echo_address);
    if (got.word !== want.word)
      report_mismatch("word", got.word, want.word);
    if (got.last !== want.last)
      report_mismatch("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reply(out_data);
  end

  task automatic send_word(input mbrm_req_t w);
    @(negedge clk);
    while (send_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_done += serve_request(w);
  endtask

  function automatic mbrm_req_t header(input logic [7:0] fn, input logic [15:0] st,
                                       input logic [15:0] cnt, input logic [15:0] v);
    mbrm_req_t r;
    r.action = ACT_HEADER;
    r.fn_code = fn;
    r.start_address = st;
    r.word_count = cnt;
    r.value = v;
    return r;
  endfunction

  function automatic mbrm_req_t data_word(input logic [15:0] v);
    mbrm_req_t r;
    r = '0;
    r.action = ACT_DATA;
    r.fn_code = 8'($urandom_range(0, 255));
    r.start_address = 16'($urandom_range(0, 65535));
    r.word_count = 16'($urandom_range(0, 65535));
    r.value = v;
    return r;
  endfunction

  // drop valid and hold until every expected word has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_base(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_HOLDING_BASE) hold_base = v;
    else in_base = v;
  endtask

  task automatic test_single_register_access();
    wait_idle();
    set_base(CFG_HOLDING_BASE, 16'h0100);
    set_base(CFG_INPUT_BASE, 16'h0120);
    send_word(header(FC_READ_HOLDING, hold_base, 16'd1, 16'd0));
    send_word(header(FC_WRITE_SINGLE, hold_base, 16'd0, 16'hFFFF));
    send_word(header(FC_WRITE_SINGLE, 16'(hold_base + NUM_REGS - 1), 16'd0, 16'h0001));
    send_word(header(FC_WRITE_SINGLE, 16'(hold_base + NUM_REGS), 16'd0, 16'h1234));
    send_word(header(FC_WRITE_SINGLE, 16'(hold_base - 1), 16'd0, 16'h4321));
    send_word(header(FC_READ_HOLDING, hold_base, 16'(MAX_IO_WORDS), 16'd0));
    send_word(header(FC_READ_INPUT, 16'(in_base + 32), 16'(MAX_IO_WORDS), 16'd0));
    send_word(header(FC_READ_HOLDING, hold_base, 16'd0, 16'd0));
    send_word(header(FC_READ_HOLDING, hold_base, 16'(MAX_IO_WORDS + 1), 16'd0));
    send_word(header(FC_READ_HOLDING, 16'(hold_base + 40), 16'd25, 16'd0));
  endtask

  task automatic test_block_writes();
    send_word(header(FC_WRITE_MULTI, 16'(hold_base + NUM_REGS - 2), 16'd2, 16'd0));
    send_word(data_word(16'hA5A5));
    send_word(data_word(16'h5A5A));
    send_word(header(FC_WRITE_MULTI, hold_base, 16'd0, 16'd0));
    // rejected block: words are swallowed, exception comes with the last
    send_word(header(FC_WRITE_MULTI, 16'(hold_base - 2), 16'd3, 16'd0));
    repeat (3) send_word(data_word(16'hDEAD));
    send_word(data_word(16'hBEEF));
    // abandon a block part way through
    send_word(header(FC_WRITE_MULTI, 16'(hold_base + 10), 16'd4, 16'd0));
    send_word(data_word(16'h1111));
    send_word(data_word(16'h2222));
    send_word(header(FC_READ_HOLDING, 16'(hold_base + 10), 16'd4, 16'd0));
  endtask

  task automatic test_unsupported_codes();
    send_word(header(FC_DIAGNOSTICS, 16'd0, 16'd0, 16'd0));
    send_word(header(FC_REPORT_ID, 16'd0, 16'd0, 16'd0));
    send_word(header(FC_ENCAP, 16'd0, 16'd0, 16'd0));
    send_word(header(FC_SPARE_LOW, 16'd0, 16'd0, 16'd0));
    send_word(header(FC_SPARE_HIGH, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(header(FC_SPARE_WRAP, 16'd0, 16'd0, 16'd0));
  endtask

  function automatic int unsigned rand_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IO_WORDS)
                                       : $urandom_range(1, 6);
  endfunction

  task automatic test_random_traffic(input int n_items, input logic [15:0] hb,
                                     input logic [15:0] ib);
    int unsigned pick, cnt, k, stop_at;
    int target;
    logic [7:0] fn;
    logic [15:0] b, st;
    wait_idle();
    set_base(CFG_HOLDING_BASE, hb);
    set_base(CFG_INPUT_BASE, ib);
    target = items_done + n_items;
    while (items_done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        fn = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
        b = (fn == FC_READ_HOLDING) ? hold_base : in_base;
        cnt = rand_len();
        st = 16'(b + $urandom_range(0, NUM_REGS - cnt));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: cnt = 0;
            1: begin
              cnt = $urandom_range(MAX_IO_WORDS + 1, NUM_REGS);
              st = b;
            end
            2: st = 16'(b - $urandom_range(1, 4));
            default: st = 16'(b + NUM_REGS - cnt + $urandom_range(1, 4));
          endcase
        end
        send_word(header(fn, st, 16'(cnt), 16'($urandom_range(0, 65535))));
      end else if (pick < 50) begin
        st = 16'(hold_base + $urandom_range(0, NUM_REGS - 1));
        if ($urandom_range(0, 9) == 0)
          st = 16'($urandom_range(0, 1) ? hold_base + NUM_REGS : hold_base - 1);
        send_word(header(FC_WRITE_SINGLE, st, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535))));
      end else if (pick < 75) begin
        cnt = rand_len();
        st = 16'(hold_base + $urandom_range(0, NUM_REGS - cnt));
        stop_at = cnt;
        if ($urandom_range(0, 11) == 0) stop_at = $urandom_range(0, cnt - 1);
        send_word(header(FC_WRITE_MULTI, st, 16'(cnt), 16'($urandom_range(0, 65535))));
        for (k = 0; k < stop_at; k++) send_word(data_word(16'($urandom_range(0, 65535))));
      end else if (pick < 83) begin
        cnt = $urandom_range(1, 8);
        case ($urandom_range(0, 2))
          0: st = 16'(hold_base - $urandom_range(1, 8));
          1: begin
            cnt = $urandom_range(MAX_IO_WORDS + 1, MAX_IO_WORDS + 8);
            st = hold_base;
          end
          default: st = 16'(hold_base + NUM_REGS - cnt + $urandom_range(1, 4));
        endcase
        send_word(header(FC_WRITE_MULTI, st, 16'(cnt), 16'd0));
        for (k = 0; k < cnt; k++) send_word(data_word(16'($urandom_range(0, 65535))));
      end else if (pick < 89) begin
        case ($urandom_range(0, 3))
          0: fn = FC_DIAGNOSTICS;
          1: fn = FC_REPORT_ID;
          2: fn = FC_ENCAP;
          default: fn = 8'($urandom_range(0, 255));
        endcase
        send_word(header(fn, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535))));
      end else if (pick < 94) begin
        send_word(data_word(16'($urandom_range(0, 65535))));
      end else begin
        send_word($urandom_range(0, 1) ? data_word(16'($urandom_range(0, 65535)))
                  : header(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
      end
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
    // close any pending block before the bases move
    send_word(header(FC_READ_HOLDING, hold_base, 16'd1, 16'd0));
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_single_register_access();
    test_block_writes();
    test_unsupported_codes();
    test_random_traffic(110, 16'h0000, 16'h0000);
    test_random_traffic(50, 16'hFFFF, 16'hFFC0);
    test_random_traffic(50, 16'hFFC0, 16'hFFFF);
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random_traffic(100, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
    test_random_traffic(120, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- modbus_register_map_server.f -----
src/mbrm_pkg.sv
src/mbrm_ram.sv
src/modbus_register_map_server.sv
tb/tb_top.sv
